FILE: hw/rtl/amu_pkg.sv
// ----------------------------------------------------------------------------
// amu_pkg
// Shared types and constants of the Adam moment update unit.
// ----------------------------------------------------------------------------
package amu_pkg;

	localparam int unsigned IDX_W           = 10;
	localparam int unsigned DATA_W          = 32;
	localparam int unsigned CFG_IDX_W       = 3;
	localparam int unsigned CFG_DATA_W      = 28;
	localparam int unsigned PARAM_DEPTH_DEF = 1024;
	localparam int unsigned MID_DEPTH       = 4;
	localparam int unsigned OUT_DEPTH       = 2;

	localparam int unsigned RHAT_W   = 44;
	localparam int unsigned X_W      = RHAT_W + 16;
	localparam int unsigned SQ_STEPS = X_W / 2;
	localparam int unsigned REM_W    = SQ_STEPS + 2;
	localparam int unsigned NUM_W    = 55;
	localparam int unsigned N_W      = 56;
	localparam int unsigned DEN_W    = 31;
	localparam int unsigned D_W      = DEN_W + 8;
	localparam int unsigned Q_W      = 32;

	localparam logic [CFG_IDX_W-1:0] REG_DECAY_FIRST     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY_SECOND    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INV_BIAS_FIRST  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INV_BIAS_SECOND = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STABILIZER      = 3'd5;

	localparam logic [15:0] RST_DECAY_FIRST     = 16'd58982;
	localparam logic [15:0] RST_DECAY_SECOND    = 16'd65470;
	localparam logic [27:0] RST_INV_BIAS_FIRST  = 28'd65536;
	localparam logic [27:0] RST_INV_BIAS_SECOND = 28'd65536;
	localparam logic [23:0] RST_STEP_SIZE       = 24'd16777;
	localparam logic [15:0] RST_STABILIZER      = 16'd1;

	localparam logic [DATA_W-1:0] S32_MAX = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] S32_MIN = 32'h8000_0000;

	typedef struct packed {
		logic [15:0] decay_first;
		logic [15:0] decay_second;
		logic [27:0] inv_bias_first;
		logic [27:0] inv_bias_second;
		logic [23:0] step_size;
		logic [15:0] stabilizer;
	} cfg_t;

	typedef struct packed {
		logic [IDX_W-1:0]         idx;
		logic signed [DATA_W-1:0] shat;
		logic [RHAT_W-1:0]        rhat;
	} mid_item_t;

	typedef struct packed {
		logic [IDX_W-1:0]         idx;
		logic signed [DATA_W-1:0] step;
	} res_t;

endpackage

FILE: hw/rtl/amu_fifo.sv
// ----------------------------------------------------------------------------
// amu_fifo
// Small register queue with combinational head read.
// ----------------------------------------------------------------------------
module amu_fifo #(
	parameter int unsigned WIDTH = 1,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty,
	output logic             full
);
	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;

	assign rd_data = mem[rd_ptr_q];
	assign empty   = (cnt_q == '0);
	assign full    = (cnt_q == CW'(DEPTH));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!wr_en && rd_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: hw/rtl/amu_front.sv
// ----------------------------------------------------------------------------
// amu_front
// Accepts items, keeps the moment stores, updates and bias-corrects moments.
// ----------------------------------------------------------------------------
module amu_front #(
	parameter int unsigned PARAM_DEPTH = amu_pkg::PARAM_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  amu_pkg::cfg_t                       cfg,
	input  logic                                push,
	output logic                                full,
	input  logic [amu_pkg::IDX_W-1:0]           param_index,
	input  logic signed [amu_pkg::DATA_W-1:0]   gradient,
	input  logic                                mid_pop,
	output logic                                mid_push,
	output amu_pkg::mid_item_t                  mid_item
);
	import amu_pkg::*;

	localparam int unsigned AW    = (PARAM_DEPTH > 1) ? $clog2(PARAM_DEPTH) : 1;
	localparam int unsigned OCC_W = $clog2(MID_DEPTH + 1);
	localparam int unsigned RED_W = IDX_W + $clog2(PARAM_DEPTH + 1);

	logic [DATA_W-1:0] mem_s [PARAM_DEPTH];
	logic [DATA_W-1:0] mem_r [PARAM_DEPTH];

	logic              clearing_q;
	logic [AW-1:0]     clr_addr_q;
	logic [OCC_W-1:0]  occ_q;

	logic              acc;
	logic [IDX_W-1:0]  red;
	logic [AW-1:0]     slot;
	logic [31:0]       ag;
	logic [63:0]       sq;
	logic [31:0]       gsq;

	logic                     v_s1;
	logic [IDX_W-1:0]         idx_s1;
	logic [AW-1:0]            slot_s1;
	logic signed [DATA_W-1:0] g_s1;
	logic [31:0]              gsq_s1;
	logic signed [DATA_W-1:0] rd_s_s1;
	logic [DATA_W-1:0]        rd_r_s1;

	logic                     v_s2;
	logic [IDX_W-1:0]         idx_s2;
	logic [AW-1:0]            slot_s2;
	logic signed [DATA_W-1:0] s_s2;
	logic [DATA_W-1:0]        r_s2;

	logic                     fwd;
	logic signed [DATA_W-1:0] s_old;
	logic [DATA_W-1:0]        r_old;
	logic [16:0]              w1;
	logic [16:0]              w2;
	logic signed [50:0]       p1a;
	logic signed [50:0]       p1b;
	logic signed [50:0]       rnd1;
	logic [49:0]              mix2;
	logic signed [DATA_W-1:0] s_new;
	logic [DATA_W-1:0]        r_new;
	logic signed [60:0]       p3;
	logic [59:0]              p4;

	assign acc  = push && !full;
	assign full = clearing_q || (occ_q >= OCC_W'(MID_DEPTH));

	// slot = index modulo depth by restoring reduction
	always_comb begin
		red = param_index;
		for (int k = IDX_W - 1; k >= 0; k--) begin
			if (RED_W'(red) >= (RED_W'(PARAM_DEPTH) << k)) begin
				red = red - IDX_W'(RED_W'(PARAM_DEPTH) << k);
			end
		end
		slot = AW'(red);
	end

	always_comb begin
		ag  = gradient[31] ? (~gradient + 32'd1) : gradient;
		sq  = 64'(ag) * 64'(ag) + 64'd32768;
		gsq = (sq[63:48] != '0) ? '1 : sq[47:16];
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			idx_s1  <= param_index;
			slot_s1 <= slot;
			g_s1    <= gradient;
			gsq_s1  <= gsq;
			rd_s_s1 <= mem_s[slot];
			rd_r_s1 <= mem_r[slot];
		end
	end

	// moment update with bypass from the previous item
	always_comb begin
		fwd   = v_s2 && (slot_s2 == slot_s1);
		s_old = fwd ? s_s2 : rd_s_s1;
		r_old = fwd ? r_s2 : rd_r_s1;
		w1    = 17'h10000 - {1'b0, cfg.decay_first};
		w2    = 17'h10000 - {1'b0, cfg.decay_second};
		p1a   = $signed({{19{s_old[31]}}, s_old}) * $signed({35'd0, cfg.decay_first});
		p1b   = $signed({{19{g_s1[31]}}, g_s1}) * $signed({34'd0, w1});
		rnd1  = p1a + p1b + 51'sd32768;
		s_new = (rnd1[50:47] == {4{rnd1[47]}}) ? rnd1[47:16] : (rnd1[50] ? S32_MIN : S32_MAX);
		mix2  = 50'(cfg.decay_second) * 50'(r_old) + 50'(w2) * 50'(gsq_s1) + 50'd32768;
		r_new = (mix2[49:48] != '0) ? '1 : mix2[47:16];
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem_s[clr_addr_q] <= '0;
			mem_r[clr_addr_q] <= '0;
		end else if (v_s1) begin
			mem_s[slot_s1] <= s_new;
			mem_r[slot_s1] <= r_new;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			idx_s2  <= idx_s1;
			slot_s2 <= slot_s1;
			s_s2    <= s_new;
			r_s2    <= r_new;
		end
	end

	// bias correction
	always_comb begin
		p3 = $signed({{29{s_s2[31]}}, s_s2}) * $signed({33'd0, cfg.inv_bias_first})
			+ 61'sd32768;
		p4 = 60'(r_s2) * 60'(cfg.inv_bias_second) + 60'd32768;
		mid_item.idx  = idx_s2;
		mid_item.shat = (p3[60:47] == {14{p3[47]}}) ? p3[47:16]
			: (p3[60] ? S32_MIN : S32_MAX);
		mid_item.rhat = p4[59:16];
	end

	assign mid_push = v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
			occ_q      <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
		end else begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			if (clearing_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == AW'(PARAM_DEPTH - 1)) begin
					clearing_q <= 1'b0;
				end
			end
			if (acc && !mid_pop) begin
				occ_q <= occ_q + 1'b1;
			end else if (!acc && mid_pop) begin
				occ_q <= occ_q - 1'b1;
			end
		end
	end

endmodule

FILE: hw/rtl/amu_back.sv
// ----------------------------------------------------------------------------
// amu_back
// Square root and divide pipeline that forms the saturated update step.
// ----------------------------------------------------------------------------
module amu_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  amu_pkg::cfg_t         cfg,
	input  logic                  mid_empty,
	input  amu_pkg::mid_item_t    mid_item,
	output logic                  mid_pop,
	input  logic                  out_full,
	output logic                  res_push,
	output amu_pkg::res_t         res
);
	import amu_pkg::*;

	localparam int unsigned SQ_N = SQ_STEPS;
	localparam int unsigned DV_N = Q_W + 1;
	localparam int unsigned CMP_W = D_W + Q_W;

	logic en;

	logic [SQ_N:0]      sq_v;
	logic [IDX_W-1:0]   sq_idx  [SQ_N+1];
	logic               sq_neg  [SQ_N+1];
	logic               sq_pos  [SQ_N+1];
	logic [NUM_W-1:0]   sq_num  [SQ_N+1];
	logic [X_W-1:0]     sq_x    [SQ_N+1];
	logic [REM_W-1:0]   sq_rem  [SQ_N+1];
	logic [SQ_N-1:0]    sq_root [SQ_N+1];
	logic [X_W-1:0]     sq_x_nx    [SQ_N];
	logic [REM_W-1:0]   sq_rem_nx  [SQ_N];
	logic [SQ_N-1:0]    sq_root_nx [SQ_N];

	logic [DV_N:0]      dv_v;
	logic [IDX_W-1:0]   dv_idx  [DV_N+1];
	logic               dv_neg  [DV_N+1];
	logic               dv_pos  [DV_N+1];
	logic               dv_zero [DV_N+1];
	logic               dv_ovf  [DV_N+1];
	logic [D_W-1:0]     dv_d    [DV_N+1];
	logic [N_W-1:0]     dv_rem  [DV_N+1];
	logic [Q_W-1:0]     dv_q    [DV_N+1];
	logic [N_W-1:0]     dv_rem_nx [DV_N];
	logic [Q_W-1:0]     dv_q_nx   [DV_N];
	logic               ovf_nx;

	logic [31:0]        ash;
	logic [DEN_W-1:0]   den;
	logic [Q_W:0]       mag;
	logic [Q_W:0]       neg_mag;

	assign en      = !out_full;
	assign mid_pop = en && !mid_empty;

	assign ash = mid_item.shat[31] ? (~mid_item.shat + 32'd1) : mid_item.shat;
	assign den = DEN_W'(sq_root[SQ_N]) + DEN_W'(cfg.stabilizer);

	for (genvar j = 0; j < SQ_N; j++) begin : g_sq
		logic [REM_W+1:0] remc;
		logic [REM_W+1:0] trial;
		logic             ge;
		assign remc  = {sq_rem[j], sq_x[j][X_W-1 -: 2]};
		assign trial = (REM_W + 2)'({sq_root[j], 2'b01});
		assign ge    = (remc >= trial);
		assign sq_rem_nx[j]  = ge ? REM_W'(remc - trial) : REM_W'(remc);
		assign sq_root_nx[j] = {sq_root[j][SQ_N-2:0], ge};
		assign sq_x_nx[j]    = sq_x[j] << 2;
	end

	assign ovf_nx = (CMP_W'(dv_rem[0]) >= (CMP_W'(dv_d[0]) << Q_W));
	assign dv_rem_nx[0] = dv_rem[0];
	assign dv_q_nx[0]   = dv_q[0];

	for (genvar i = 1; i < DV_N; i++) begin : g_dv
		logic [CMP_W-1:0] shifted;
		logic             ge;
		assign shifted      = CMP_W'(dv_d[i]) << (Q_W - i);
		assign ge           = (CMP_W'(dv_rem[i]) >= shifted);
		assign dv_rem_nx[i] = ge ? (dv_rem[i] - N_W'(shifted)) : dv_rem[i];
		assign dv_q_nx[i]   = dv_q[i] | (Q_W'(ge) << (Q_W - i));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_idx[0]  <= mid_item.idx;
			sq_neg[0]  <= mid_item.shat[31];
			sq_pos[0]  <= !mid_item.shat[31] && (mid_item.shat != '0);
			sq_num[0]  <= NUM_W'(cfg.step_size) * NUM_W'(ash);
			sq_x[0]    <= {mid_item.rhat, 16'd0};
			sq_rem[0]  <= '0;
			sq_root[0] <= '0;
			for (int j = 0; j < SQ_N; j++) begin
				sq_idx[j+1]  <= sq_idx[j];
				sq_neg[j+1]  <= sq_neg[j];
				sq_pos[j+1]  <= sq_pos[j];
				sq_num[j+1]  <= sq_num[j];
				sq_x[j+1]    <= sq_x_nx[j];
				sq_rem[j+1]  <= sq_rem_nx[j];
				sq_root[j+1] <= sq_root_nx[j];
			end
			dv_idx[0]  <= sq_idx[SQ_N];
			dv_neg[0]  <= sq_neg[SQ_N];
			dv_pos[0]  <= sq_pos[SQ_N];
			dv_zero[0] <= (den == '0);
			dv_ovf[0]  <= 1'b0;
			dv_d[0]    <= {den, 8'd0};
			dv_rem[0]  <= N_W'(sq_num[SQ_N]) + N_W'({den, 7'd0});
			dv_q[0]    <= '0;
			for (int i = 0; i < DV_N; i++) begin
				dv_idx[i+1]  <= dv_idx[i];
				dv_neg[i+1]  <= dv_neg[i];
				dv_pos[i+1]  <= dv_pos[i];
				dv_zero[i+1] <= dv_zero[i];
				dv_ovf[i+1]  <= (i == 0) ? ovf_nx : dv_ovf[i];
				dv_d[i+1]    <= dv_d[i];
				dv_rem[i+1]  <= dv_rem_nx[i];
				dv_q[i+1]    <= dv_q_nx[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v <= '0;
			dv_v <= '0;
		end else if (en) begin
			sq_v <= {sq_v[SQ_N-1:0], !mid_empty};
			dv_v <= {dv_v[DV_N-1:0], sq_v[SQ_N]};
		end
	end

	// sign and saturation of the quotient
	always_comb begin
		mag     = dv_ovf[DV_N] ? {1'b1, {Q_W{1'b0}}} : {1'b0, dv_q[DV_N]};
		neg_mag = ~mag + 1'b1;
		res.idx = dv_idx[DV_N];
		if (dv_zero[DV_N]) begin
			res.step = dv_pos[DV_N] ? S32_MIN : (dv_neg[DV_N] ? S32_MAX : '0);
		end else if (dv_pos[DV_N]) begin
			res.step = (mag > (Q_W + 1)'(S32_MIN)) ? S32_MIN : neg_mag[Q_W-1:0];
		end else begin
			res.step = (mag > (Q_W + 1)'(S32_MAX)) ? S32_MAX : mag[Q_W-1:0];
		end
	end

	assign res_push = en && dv_v[DV_N];

endmodule

FILE: hw/rtl/adam_moment_update_unit.sv
// Throughput: one item per cycle while a full result queue does not stall it; a 30-step root
// pipeline and a 33-step divide pipeline each retire one item per unstalled cycle.
// Reset: configuration returns to defaults; both moment stores are zeroed by a
// sweep over all PARAM_DEPTH slots (1024 by default) during which full stays high.
// ----------------------------------------------------------------------------
// adam_moment_update_unit
// Adam moment update with per-parameter first and second moment stores.
// ----------------------------------------------------------------------------
module adam_moment_update_unit #(
	parameter int unsigned PARAM_DEPTH = amu_pkg::PARAM_DEPTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	output logic                                  full,
	input  logic [amu_pkg::IDX_W-1:0]             param_index,
	input  logic signed [amu_pkg::DATA_W-1:0]     gradient,
	output logic                                  empty,
	input  logic                                  pop,
	output logic [amu_pkg::IDX_W-1:0]             out_index,
	output logic signed [amu_pkg::DATA_W-1:0]     update_step,
	input  logic                                  cfg_write,
	input  logic [amu_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [amu_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import amu_pkg::*;

	localparam int unsigned MID_W = $bits(mid_item_t);
	localparam int unsigned RES_W = $bits(res_t);

	cfg_t             cfg_q;
	logic             mid_push;
	mid_item_t        mid_in;
	logic [MID_W-1:0] mid_rd;
	mid_item_t        mid_head;
	logic             mid_empty;
	logic             mid_full;
	logic             mid_pop;
	logic             res_push;
	res_t             res_in;
	logic [RES_W-1:0] res_rd;
	res_t             res_head;
	logic             out_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.decay_first     <= RST_DECAY_FIRST;
			cfg_q.decay_second    <= RST_DECAY_SECOND;
			cfg_q.inv_bias_first  <= RST_INV_BIAS_FIRST;
			cfg_q.inv_bias_second <= RST_INV_BIAS_SECOND;
			cfg_q.step_size       <= RST_STEP_SIZE;
			cfg_q.stabilizer      <= RST_STABILIZER;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_DECAY_FIRST:     cfg_q.decay_first     <= cfg_data[15:0];
				REG_DECAY_SECOND:    cfg_q.decay_second    <= cfg_data[15:0];
				REG_INV_BIAS_FIRST:  cfg_q.inv_bias_first  <= cfg_data[27:0];
				REG_INV_BIAS_SECOND: cfg_q.inv_bias_second <= cfg_data[27:0];
				REG_STEP_SIZE:       cfg_q.step_size       <= cfg_data[23:0];
				REG_STABILIZER:      cfg_q.stabilizer      <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	amu_front #(
		.PARAM_DEPTH(PARAM_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.push       (push),
		.full       (full),
		.param_index(param_index),
		.gradient   (gradient),
		.mid_pop    (mid_pop),
		.mid_push   (mid_push),
		.mid_item   (mid_in)
	);

	amu_fifo #(
		.WIDTH(MID_W),
		.DEPTH(MID_DEPTH)
	) u_mid_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (mid_push),
		.wr_data(mid_in),
		.rd_en  (mid_pop),
		.rd_data(mid_rd),
		.empty  (mid_empty),
		.full   (mid_full)
	);

	assign mid_head = mid_item_t'(mid_rd);

	amu_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.mid_empty(mid_empty),
		.mid_item (mid_head),
		.mid_pop  (mid_pop),
		.out_full (out_full),
		.res_push (res_push),
		.res      (res_in)
	);

	amu_fifo #(
		.WIDTH(RES_W),
		.DEPTH(OUT_DEPTH)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (res_push),
		.wr_data(res_in),
		.rd_en  (pop && !empty),
		.rd_data(res_rd),
		.empty  (empty),
		.full   (out_full)
	);

	assign res_head    = res_t'(res_rd);
	assign out_index   = res_head.idx;
	assign update_step = res_head.step;

	// mid queue can never overflow: front admission is credit based
	logic unused_mid_full;
	assign unused_mid_full = mid_full;

endmodule

FILE: hw/rtl/amu_checker.sv
// ----------------------------------------------------------------------------
// amu_checker
// Port-level checks of the Adam moment update unit, bound to the top level.
// ----------------------------------------------------------------------------
module amu_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              push,
	input logic                              full,
	input logic                              empty,
	input logic                              pop,
	input logic [amu_pkg::IDX_W-1:0]         out_index,
	input logic signed [amu_pkg::DATA_W-1:0] update_step
);
	import amu_pkg::*;

	logic [7:0] outst_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outst_q <= '0;
		end else if ((push && !full) && !(pop && !empty)) begin
			outst_q <= outst_q + 1'b1;
		end else if (!(push && !full) && (pop && !empty)) begin
			outst_q <= outst_q - 1'b1;
		end
	end

	a_head_held: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty)
		else $error("result head dropped without transfer");

	a_head_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> $stable(out_index) && $stable(update_step))
		else $error("result head changed without transfer");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		(outst_q == '0) |-> empty)
		else $error("result shown with no item outstanding");

	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> full)
		else $error("input open during store clearing");

endmodule

bind adam_moment_update_unit amu_checker u_amu_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.push       (push),
	.full       (full),
	.empty      (empty),
	.pop        (pop),
	.out_index  (out_index),
	.update_step(update_step)
);

FILE: verif/adam_moment_update_unit_tb.sv
// ----------------------------------------------------------------------------
// adam_moment_update_unit_tb
// Self-checking bench for the Adam moment update unit: gradients are pushed in
// random bursts, results are popped on a shifting stall pattern and compared
// against a cycle-free fixed-point model of the moment stores, over several
// register settings including the extremes and a zero denominator.
// ----------------------------------------------------------------------------
class adam_step_board;
	longint first_m [1024];
	longint second_m [1024];
	longint d1, d2, ib1, ib2, lr, stab;
	amu_pkg::res_t pending_steps [$];
	int errors;
	int accepted;
	int checked;

	function new();
		d1 = amu_pkg::RST_DECAY_FIRST;
		d2 = amu_pkg::RST_DECAY_SECOND;
		ib1 = amu_pkg::RST_INV_BIAS_FIRST;
		ib2 = amu_pkg::RST_INV_BIAS_SECOND;
		lr = amu_pkg::RST_STEP_SIZE;
		stab = amu_pkg::RST_STABILIZER;
		foreach (first_m[i]) begin
			first_m[i] = 0;
			second_m[i] = 0;
		end
	endfunction

	function void set_reg(logic [2:0] index, logic [27:0] value);
		case (index)
			amu_pkg::REG_DECAY_FIRST: d1 = value[15:0];
			amu_pkg::REG_DECAY_SECOND: d2 = value[15:0];
			amu_pkg::REG_INV_BIAS_FIRST: ib1 = value;
			amu_pkg::REG_INV_BIAS_SECOND: ib2 = value;
			amu_pkg::REG_STEP_SIZE: lr = value[23:0];
			amu_pkg::REG_STABILIZER: stab = value[15:0];
			default: ;
		endcase
	endfunction

	static function longint clamp_s32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	static function longint int_sqrt(longint unsigned x);
		longint unsigned root;
		longint unsigned bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > x) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (x >= root + bitv) begin
				x = x - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return longint'(root);
	endfunction

	function amu_pkg::res_t next_step(logic [9:0] idx, logic signed [31:0] g);
		longint gv, s, r, mix, ag, gsq, shat, rhat, den, num, dv, mag, step;
		amu_pkg::res_t res;
		gv = g;
		mix = d1 * first_m[idx] + (65536 - d1) * gv;
		s = clamp_s32((mix + 32768) >>> 16);
		first_m[idx] = s;
		ag = (gv < 0) ? -gv : gv;
		gsq = (ag * ag + 32768) >> 16;
		if (gsq > 64'hFFFF_FFFF) gsq = 64'hFFFF_FFFF;
		mix = d2 * second_m[idx] + (65536 - d2) * gsq;
		r = (mix + 32768) >> 16;
		if (r > 64'hFFFF_FFFF) r = 64'hFFFF_FFFF;
		second_m[idx] = r;
		shat = clamp_s32((s * ib1 + 32768) >>> 16);
		rhat = (r * ib2 + 32768) >> 16;
		den = int_sqrt(rhat << 16) + stab;
		if (den == 0) begin
			step = (shat == 0) ? 0 : (shat > 0) ? -64'sd2147483648 : 64'sd2147483647;
		end else begin
			num = lr * ((shat < 0) ? -shat : shat);
			dv = den << 8;
			mag = (num + (dv >> 1)) / dv;
			if (mag > (64'sd1 << 32)) mag = 64'sd1 << 32;
			step = clamp_s32((shat > 0) ? -mag : mag);
		end
		res.idx = idx;
		res.step = step[31:0];
		return res;
	endfunction

	function void note_gradient(logic [9:0] idx, logic signed [31:0] g);
		pending_steps.push_back(next_step(idx, g));
		accepted++;
	endfunction

	function void check_result(logic [9:0] idx, logic signed [31:0] step);
		amu_pkg::res_t exp_r;
		if (pending_steps.size() == 0) begin
			$display("%0t: unexpected result idx %0d step %0d", $time, idx, step);
			errors++;
			return;
		end
		exp_r = pending_steps.pop_front();
		checked++;
		if (idx !== exp_r.idx) begin
			$display("%0t: out_index expected %0d actual %0d", $time, exp_r.idx, idx);
			errors++;
		end
		if (step !== exp_r.step) begin
			$display("%0t: update_step idx %0d expected %0d actual %0d",
				$time, exp_r.idx, exp_r.step, step);
			errors++;
		end
	endfunction
endclass

module adam_moment_update_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import amu_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam int LIMIT = 400000;
	localparam int NUM_PHASES = 6;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic [IDX_W-1:0] param_index = '0;
	logic signed [DATA_W-1:0] gradient = '0;
	logic empty;
	logic pop = 1'b0;
	logic [IDX_W-1:0] out_index;
	logic signed [DATA_W-1:0] update_step;
	logic cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	adam_step_board board;
	int cycles = 0;
	bit held = 1'b0;

	adam_moment_update_unit u_top (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.param_index(param_index), .gradient(gradient), .empty(empty), .pop(pop),
		.out_index(out_index), .update_step(update_step), .cfg_write(cfg_write),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// result side: check on transfer, stall on a shifting pattern and in one long hold
	initial begin
		int hold;
		int mode;
		board = new();
		forever begin
			@(posedge clk);
			if (pop && !empty) board.check_result(out_index, update_step);
			if (!held && board.accepted >= 150) begin
				held = 1'b1;
				hold = 300;
			end
			mode = (cycles / 97) % 4;
			if (hold > 0) begin
				hold--;
				pop <= 1'b0;
			end else if (mode == 0) pop <= 1'b1;
			else if (mode == 1) pop <= 1'($urandom_range(0, 1));
			else if (mode == 2) pop <= ($urandom_range(0, 3) == 0);
			else pop <= ($urandom_range(0, 9) < 8);
		end
	end

	task automatic send_gradient(logic [IDX_W-1:0] idx, logic signed [DATA_W-1:0] g);
		push <= 1'b1;
		param_index <= idx;
		gradient <= g;
		do @(posedge clk); while (full);
		board.note_gradient(idx, g);
	endtask

	task automatic idle_gap(int n);
		push <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic load_regs(logic [27:0] v0, logic [27:0] v1, logic [27:0] v2,
			logic [27:0] v3, logic [27:0] v4, logic [27:0] v5);
		logic [27:0] vals [8];
		logic [CFG_IDX_W-1:0] ids [8];
		vals = '{v0, v1, v2, v3, v4, v5, 28'($urandom()), 28'($urandom())};
		ids = '{REG_DECAY_FIRST, REG_DECAY_SECOND, REG_INV_BIAS_FIRST,
			REG_INV_BIAS_SECOND, REG_STEP_SIZE, REG_STABILIZER, REG_SPARE_LO, REG_SPARE_HI};
		for (int i = 0; i < 8; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= ids[i];
			cfg_data <= vals[i];
			@(posedge clk);
			board.set_reg(ids[i], vals[i]);
		end
		cfg_write <= 1'b0;
	endtask

	task automatic wait_drained();
		while (board.pending_steps.size() != 0) @(posedge clk);
	endtask

	function automatic logic signed [DATA_W-1:0] pick_gradient();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return $signed($urandom_range(0, 131071)) - 65536;
			2: return ($urandom_range(0, 1)) ? S32_MAX : S32_MIN;
			3: return $signed($urandom()) >>> $urandom_range(0, 24);
			default: return $signed($urandom_range(0, 8388607)) - 4194304;
		endcase
	endfunction

	task automatic random_stream(int n);
		int sent;
		int burst;
		logic [IDX_W-1:0] idx;
		sent = 0;
		while (sent < n) begin
			burst = $urandom_range(1, 24);
			for (int i = 0; i < burst && sent < n; i++) begin
				idx = ($urandom_range(0, 1)) ? IDX_W'($urandom_range(0, 15))
					: IDX_W'($urandom_range(0, 1023));
				send_gradient(idx, pick_gradient());
				sent++;
			end
			if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 8));
		end
		idle_gap(0);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		do @(posedge clk); while (full);

		// defaults first: field extremes and repeated updates of several parameters
		send_gradient(10'd0, 32'sd0);
		send_gradient(10'd1023, S32_MAX);
		send_gradient(10'd1023, S32_MAX);
		send_gradient(10'd1, S32_MIN);
		send_gradient(10'd1, S32_MIN);
		send_gradient(10'd2, -32'sd1);
		send_gradient(10'd3, 32'sd1);
		send_gradient(10'h2AA, 32'sh5555_5555);
		send_gradient(10'h155, 32'shAAAA_AAAA);
		for (int i = 0; i < 6; i++) send_gradient(10'd7, 32'sd65536);
		idle_gap(0);
		random_stream(75);
		wait_drained();

		for (int ph = 1; ph < NUM_PHASES; ph++) begin
			case (ph)
				1: load_regs(28'd0, 28'd0, 28'hFFF_FFFF, 28'hFFF_FFFF, 28'hFF_FFFF, 28'd0);
				2: load_regs(28'hFFFF, 28'hFFFF, 28'd0, 28'd65536, 28'd16777, 28'hFFFF);
				3: load_regs(28'd32768, 28'd60000, 28'd200000, 28'd0, 28'hFF_FFFF, 28'd0);
				4: load_regs(28'($urandom_range(0, 65535)), 28'($urandom_range(0, 65535)),
					28'($urandom_range(0, 1048576)), 28'($urandom_range(0, 1048576)),
					28'($urandom_range(0, 16777215)), 28'($urandom_range(0, 65535)));
				default: load_regs(28'd58982, 28'd65470, 28'd700000, 28'd6553600,
					28'd16777, 28'd1);
			endcase
			if (ph == 3) begin
				// zero root with zero stabilizer: saturated or zero step
				send_gradient(10'd100, 32'sd65536);
				send_gradient(10'd101, -32'sd65536);
				send_gradient(10'd102, 32'sd0);
				idle_gap(0);
			end
			random_stream(75);
			wait_drained();
		end

		repeat (100) @(posedge clk);
		$display("Covered %0d gradients over %0d register settings, %0d results checked,",
			board.accepted, NUM_PHASES, board.checked);
		$display("with random bursts, receiver stalls and one long back-pressure hold.");
		if (board.errors == 0 && board.pending_steps.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
